// ===== sv/sal_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sequential array list.
// No dependencies; imported by the channel interfaces, the top level and the bench.
package sal_pkg;

  // Store depth, the widths that follow from it, and the data, opcode and status widths
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned ST_W     = 3;

  // Request opcodes
  typedef enum logic [OP_W-1:0] {
    OP_APPEND      = 3'd0,
    OP_REMOVE_LAST = 3'd1,
    OP_REMOVE_HEAD = 3'd2,
    OP_REMOVE_AT   = 3'd3,
    OP_SEARCH      = 3'd4
  } opcode_e;

  // Result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_RANGE     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

endpackage

// ===== sv/sal_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results.
// Depends on sal_pkg for field widths.
interface sal_req_if;
  import sal_pkg::*;

  logic                     valid;
  logic                     ready;
  logic        [OP_W-1:0]   opcode;
  logic signed [DATA_W-1:0] value;
  logic        [IDX_W-1:0]  index;

  modport source (output valid, opcode, value, index, input ready);
  modport sink   (input valid, opcode, value, index, output ready);
endinterface

interface sal_rsp_if;
  import sal_pkg::*;

  logic                     valid;
  logic                     ready;
  logic        [ST_W-1:0]   status;
  logic        [IDX_W-1:0]  found_index;
  logic signed [DATA_W-1:0] removed_value;
  logic        [CNT_W-1:0]  count;

  modport source (output valid, status, found_index, removed_value, count, input ready);
  modport sink   (input valid, status, found_index, removed_value, count, output ready);
endinterface

// ===== sv/sequential_array_list.sv =====
`timescale 1ns / 1ps
// Sequential array list top level: store, element counter and sequencer.
// Depends on sal_pkg and the channel interfaces in sal_if.sv.

// A packed list of up to CAPACITY (16) signed 32-bit entries with one
// request in flight at a time. Each accepted request transaction gives
// exactly one result transaction; the request side is ready only while
// the block is idle, and the result is held until it is taken. Timing is
// set by the store and its registered read: append and any rejected or
// unknown request give result valid in the cycle after accept; a removal
// reads out the entry at position p, then moves each later entry down in
// a read step and a write step (S_SHIFT_RD, S_SHIFT_WR); a search walks
// one entry per cycle until a hit or the last entry. The longest request
// is removing the head of a full list. The block returns to idle at the
// edge that takes the result, and a new request can be accepted from then
// on.
module sequential_array_list (
  input  logic     clk_i,
  input  logic     rst_ni,
  sal_req_if.sink   in_i,
  sal_rsp_if.source out_o
);
  import sal_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAKE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SEARCH,
    S_DONE
  } state_e;

  state_e                    state_q;
  logic        [CNT_W-1:0]   count_q;
  logic        [IDX_W-1:0]   ptr_q;
  logic signed [DATA_W-1:0]  value_q;
  logic        [ST_W-1:0]    status_q;
  logic        [IDX_W-1:0]   found_q;
  logic signed [DATA_W-1:0]  removed_q;

  // Store with one write and one registered read port
  logic signed [DATA_W-1:0]  mem [CAPACITY];
  logic signed [DATA_W-1:0]  rdata_q;
  logic        [IDX_W-1:0]   raddr;
  logic                      we;
  logic        [IDX_W-1:0]   waddr;
  logic signed [DATA_W-1:0]  wdata;

  logic                      accept;
  logic                      is_empty;
  logic                      is_full;
  logic        [IDX_W-1:0]   rm_pos;
  logic        [CNT_W-1:0]   ptr_inc;
  logic        [CNT_W-1:0]   ptr_inc2;

  assign accept   = in_i.valid && in_i.ready;
  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CNT_W'(CAPACITY));
  assign ptr_inc  = {1'b0, ptr_q} + CNT_W'(1);
  assign ptr_inc2 = {1'b0, ptr_q} + CNT_W'(2);

  // Position taken out by a removal request
  always_comb begin
    case (in_i.opcode)
      OP_REMOVE_LAST: rm_pos = IDX_W'(count_q - CNT_W'(1));
      OP_REMOVE_HEAD: rm_pos = '0;
      default:        rm_pos = in_i.index;
    endcase
  end

  // Read address and write port control
  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = ptr_q;
    wdata = rdata_q;
    case (state_q)
      S_IDLE: begin
        raddr = (in_i.opcode == OP_SEARCH) ? '0 : rm_pos;
        if (accept && in_i.opcode == OP_APPEND && !is_full) begin
          we    = 1'b1;
          waddr = IDX_W'(count_q);
          wdata = in_i.value;
        end
      end
      S_SHIFT_RD: raddr = ptr_inc[IDX_W-1:0];
      S_SHIFT_WR: we    = 1'b1;
      S_SEARCH:   raddr = ptr_inc[IDX_W-1:0];
      default:    raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // Sequencer, counter and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      ptr_q     <= '0;
      value_q   <= '0;
      status_q  <= ST_OK;
      found_q   <= '0;
      removed_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            value_q   <= in_i.value;
            status_q  <= ST_OK;
            found_q   <= '0;
            removed_q <= '0;
            ptr_q     <= '0;
            state_q   <= S_DONE;
            case (in_i.opcode)
              OP_APPEND: begin
                if (is_full) begin
                  status_q <= ST_FULL;
                end else begin
                  count_q <= count_q + CNT_W'(1);
                end
              end
              OP_REMOVE_LAST, OP_REMOVE_HEAD, OP_REMOVE_AT: begin
                if (is_empty) begin
                  status_q <= ST_EMPTY;
                end else if (in_i.opcode == OP_REMOVE_AT &&
                             {1'b0, in_i.index} >= count_q) begin
                  status_q <= ST_RANGE;
                end else begin
                  ptr_q   <= rm_pos;
                  state_q <= S_TAKE;
                end
              end
              OP_SEARCH: begin
                if (is_empty) begin
                  status_q <= ST_NOT_FOUND;
                end else begin
                  state_q <= S_SEARCH;
                end
              end
              default: ;
            endcase
          end
        end
        // Removed entry is on the read port now
        S_TAKE: begin
          removed_q <= rdata_q;
          if (ptr_inc < count_q) begin
            state_q <= S_SHIFT_RD;
          end else begin
            count_q <= count_q - CNT_W'(1);
            state_q <= S_DONE;
          end
        end
        S_SHIFT_RD: state_q <= S_SHIFT_WR;
        // Entry at ptr+1 is written down to ptr
        S_SHIFT_WR: begin
          ptr_q <= ptr_inc[IDX_W-1:0];
          if (ptr_inc2 < count_q) begin
            state_q <= S_SHIFT_RD;
          end else begin
            count_q <= count_q - CNT_W'(1);
            state_q <= S_DONE;
          end
        end
        // One entry compared per cycle; the next read is already issued
        S_SEARCH: begin
          if (rdata_q == value_q) begin
            found_q <= ptr_q;
            state_q <= S_DONE;
          end else if (ptr_inc >= count_q) begin
            status_q <= ST_NOT_FOUND;
            state_q  <= S_DONE;
          end else begin
            ptr_q <= ptr_inc[IDX_W-1:0];
          end
        end
        S_DONE: begin
          if (out_o.ready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = (state_q == S_DONE);
  assign out_o.status        = status_q;
  assign out_o.found_index   = found_q;
  assign out_o.removed_value = removed_q;
  assign out_o.count         = count_q;

endmodule

// ===== bench/sal_list_checker.sv =====
`timescale 1ns / 1ps
// Checker for the sequential array list: watches both channels, predicts each result.
// Depends on sal_pkg and the channel interfaces in sal_if.sv.
module sal_list_checker (
  input  logic clk_i,
  input  logic rst_ni,
  sal_req_if   req_i,
  sal_rsp_if   rsp_i,
  output int   fail_count_o,
  output int   pending_o
);
  import sal_pkg::*;

  typedef struct packed {
    logic        [ST_W-1:0]   status;
    logic        [IDX_W-1:0]  found_index;
    logic signed [DATA_W-1:0] removed_value;
    logic        [CNT_W-1:0]  count;
  } list_result_t;

  // Shadow copy of the list
  logic signed [DATA_W-1:0] list_mem [CAPACITY];
  int                       list_len;

  list_result_t             expected_q [$];
  list_result_t             want;
  list_result_t             got;
  int                       fail_total;

  // Take the entry at pos out and close the gap behind it
  function automatic logic signed [DATA_W-1:0] take_entry(int pos);
    logic signed [DATA_W-1:0] taken;
    taken = list_mem[pos];
    for (int k = pos; k + 1 < list_len; k++) begin
      list_mem[k] = list_mem[k + 1];
    end
    list_len--;
    list_mem[list_len] = '0;
    return taken;
  endfunction

  // Apply one request to the shadow list and return the answer it gives
  function automatic list_result_t apply_request(logic [OP_W-1:0] op,
                                                 logic signed [DATA_W-1:0] val,
                                                 logic [IDX_W-1:0] idx);
    list_result_t res;
    res = '0;
    case (op)
      OP_APPEND: begin
        if (list_len < CAPACITY) begin
          list_mem[list_len] = val;
          list_len++;
        end else begin
          res.status = ST_FULL;
        end
      end
      OP_REMOVE_LAST: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else res.removed_value = take_entry(list_len - 1);
      end
      OP_REMOVE_HEAD: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else res.removed_value = take_entry(0);
      end
      OP_REMOVE_AT: begin
        // empty wins over the index check
        if (list_len == 0) res.status = ST_EMPTY;
        else if (int'(idx) >= list_len) res.status = ST_RANGE;
        else res.removed_value = take_entry(int'(idx));
      end
      OP_SEARCH: begin
        res.status = ST_NOT_FOUND;
        for (int k = 0; k < list_len; k++) begin
          if (res.status == ST_NOT_FOUND && list_mem[k] == val) begin
            res.status      = ST_OK;
            res.found_index = IDX_W'(k);
          end
        end
      end
      default: ;  // spare opcodes leave everything alone
    endcase
    res.count = CNT_W'(list_len);
    return res;
  endfunction

  function automatic int count_mismatches(list_result_t exp_r, list_result_t act_r);
    int bad;
    bad = 0;
    if (act_r.status !== exp_r.status) begin
      $error("status: expected %0d, actual %0d", exp_r.status, act_r.status);
      bad++;
    end
    if (act_r.found_index !== exp_r.found_index) begin
      $error("found_index: expected %0d, actual %0d", exp_r.found_index, act_r.found_index);
      bad++;
    end
    if (act_r.removed_value !== exp_r.removed_value) begin
      $error("removed_value: expected %0d, actual %0d",
             exp_r.removed_value, act_r.removed_value);
      bad++;
    end
    if (act_r.count !== exp_r.count) begin
      $error("count: expected %0d, actual %0d", exp_r.count, act_r.count);
      bad++;
    end
    return bad;
  endfunction

  // Result transactions are checked before the same edge's request is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_len = 0;
      for (int k = 0; k < CAPACITY; k++) list_mem[k] = '0;
      expected_q.delete();
      fail_total = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        got = {rsp_i.status, rsp_i.found_index, rsp_i.removed_value, rsp_i.count};
        if (expected_q.size() == 0) begin
          $error("result transaction with nothing expected: status %0d count %0d",
                 rsp_i.status, rsp_i.count);
          fail_total++;
        end else begin
          want = expected_q.pop_front();
          fail_total += count_mismatches(want, got);
        end
      end
      if (req_i.valid && req_i.ready) begin
        expected_q.push_back(apply_request(req_i.opcode, req_i.value, req_i.index));
      end
      fail_count_o <= fail_total;
      pending_o    <= expected_q.size();
    end
  end

endmodule

// ===== bench/tb_sequential_array_list.sv =====
`timescale 1ns / 1ps
// Testbench top for the sequential array list: clock, reset, stimulus, verdict.
// Depends on sal_pkg, sal_if.sv, the block and bench/sal_list_checker.sv.
module tb_sequential_array_list;
  import sal_pkg::*;

  // Spare opcodes the block must answer without touching the list
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  localparam int RANDOM_ITEMS = 1200;
  localparam int PHASE_LEN    = 40;
  localparam int IDLE_PCT     = 38;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int TAIL_CYCLES  = 40;

  logic clk_i;
  logic rst_ni;

  sal_req_if req_ch ();
  sal_rsp_if rsp_ch ();

  int  fail_count;
  int  pending;
  bit  gaps_on;
  bit  hold_request;
  bit  hold_served;

  logic signed [DATA_W-1:0] value_pool [$];

  sequential_array_list dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (rsp_ch)
  );

  sal_list_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 100 MHz clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: random back-pressure plus one long hold-off
  initial begin
    rsp_ch.ready <= 1'b0;
    hold_served = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        rsp_ch.ready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk_i);
        rsp_ch.ready <= 1'b1;
      end else if (gaps_on) begin
        rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one request transaction and wait until it is taken
  task automatic send_request(input logic [OP_W-1:0] op,
                              input logic signed [DATA_W-1:0] val,
                              input logic [IDX_W-1:0] idx);
    if (gaps_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        req_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    req_ch.valid  <= 1'b1;
    req_ch.opcode <= op;
    req_ch.value  <= val;
    req_ch.index  <= idx;
    do @(posedge clk_i); while (!req_ch.ready);
    if (op == OP_APPEND) begin
      value_pool.push_back(val);
      if (value_pool.size() > 32) void'(value_pool.pop_front());
    end
  endtask

  // Mix of extremes, small repeated values and full-range random words
  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 15) begin
      case ($urandom_range(3))
        0: return {1'b1, {(DATA_W-1){1'b0}}};
        1: return {1'b0, {(DATA_W-1){1'b1}}};
        2: return '0;
        default: return '1;
      endcase
    end
    if (r < 35) return DATA_W'($urandom_range(4, 1));
    return $urandom;
  endfunction

  // Search keys mostly come from values already appended
  function automatic logic signed [DATA_W-1:0] pick_key();
    if (value_pool.size() != 0 && $urandom_range(99) < 60)
      return value_pool[$urandom_range(value_pool.size() - 1)];
    return pick_value();
  endfunction

  function automatic logic [OP_W-1:0] pick_removal();
    case ($urandom_range(2))
      0: return OP_REMOVE_LAST;
      1: return OP_REMOVE_HEAD;
      default: return OP_REMOVE_AT;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_spare();
    case ($urandom_range(2))
      0: return OP_SPARE_A;
      1: return OP_SPARE_B;
      default: return OP_SPARE_C;
    endcase
  endfunction

  // Phase 0 grows the list, 1 drains it, 2 mixes freely
  function automatic logic [OP_W-1:0] pick_opcode(int phase);
    int r;
    int app_pct;
    int srch_pct;
    int rem_pct;
    r = $urandom_range(99);
    case (phase)
      0: begin app_pct = 70; srch_pct = 10; rem_pct = 15; end
      1: begin app_pct = 20; srch_pct = 10; rem_pct = 65; end
      default: begin app_pct = 40; srch_pct = 25; rem_pct = 30; end
    endcase
    if (r < app_pct) return OP_APPEND;
    if (r < app_pct + srch_pct) return OP_SEARCH;
    if (r < app_pct + srch_pct + rem_pct) return pick_removal();
    return pick_spare();
  endfunction

  // Stimulus and verdict
  initial begin
    int                       phase;
    int                       guard;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] val;
    logic [IDX_W-1:0]         idx;

    gaps_on      = 1'b1;
    hold_request = 1'b0;
    rst_ni        <= 1'b0;
    req_ch.valid  <= 1'b0;
    req_ch.opcode <= OP_APPEND;
    req_ch.value  <= '0;
    req_ch.index  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Removals and search on an empty list
    send_request(OP_REMOVE_LAST, '0, '0);
    send_request(OP_REMOVE_HEAD, '0, '0);
    send_request(OP_REMOVE_AT, '0, IDX_W'(5));
    send_request(OP_SEARCH, '0, '0);
    // Spare opcodes
    send_request(OP_SPARE_A, '1, '1);
    send_request(OP_SPARE_B, '0, '0);
    send_request(OP_SPARE_C, '1, '1);
    // Extreme values, one repeated so the first match must win
    send_request(OP_APPEND, {1'b1, {(DATA_W-1){1'b0}}}, '0);
    send_request(OP_APPEND, {1'b0, {(DATA_W-1){1'b1}}}, '0);
    send_request(OP_APPEND, '0, '0);
    send_request(OP_APPEND, '1, '0);
    send_request(OP_APPEND, {1'b0, {(DATA_W-1){1'b1}}}, '1);
    send_request(OP_SEARCH, {1'b0, {(DATA_W-1){1'b1}}}, '0);
    send_request(OP_SEARCH, DATA_W'(12345), '0);
    send_request(OP_SEARCH, '1, '0);
    // Index past the end, then removals from the middle and both ends
    send_request(OP_REMOVE_AT, '0, '1);
    send_request(OP_REMOVE_AT, '0, IDX_W'(5));
    send_request(OP_REMOVE_AT, '0, IDX_W'(1));
    send_request(OP_REMOVE_HEAD, '0, '0);
    send_request(OP_REMOVE_LAST, '0, '0);
    send_request(OP_SEARCH, '1, '0);
    send_request(OP_REMOVE_AT, '0, '0);

    // Random phases that fill and drain the list
    phase = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0 && n != 0) phase = $urandom_range(2);
      gaps_on = !(n >= 300 && n < 450);
      if (n == 700) hold_request = 1'b1;
      op  = pick_opcode(phase);
      val = (op == OP_SEARCH) ? pick_key() : pick_value();
      idx = ($urandom_range(1) != 0) ? IDX_W'($urandom_range(15)) : IDX_W'($urandom_range(3));
      send_request(op, val, idx);
    end
    req_ch.valid <= 1'b0;
    // Pending count includes the last request only after this edge
    @(posedge clk_i);

    // Let the last results come out, then watch for strays
    guard = 0;
    while (pending != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/sal_pkg.sv
sv/sal_if.sv
sv/sequential_array_list.sv
bench/sal_list_checker.sv
bench/tb_sequential_array_list.sv
